FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/ffpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffpc_pkg
// Shared constants, register codes and lane control type of the compressor.
// ----------------------------------------------------------------------------
package ffpc_pkg;

	localparam int CHANNELS    = 2;
	localparam int SAMPLE_BITS = 24;
	localparam int ADDR_W      = 5;

	localparam logic [2:0] REG_ENABLE   = 3'd0;
	localparam logic [2:0] REG_IN_GAIN  = 3'd1;
	localparam logic [2:0] REG_THRESH   = 3'd2;
	localparam logic [2:0] REG_RATIO    = 3'd3;
	localparam logic [2:0] REG_ATTACK   = 3'd4;
	localparam logic [2:0] REG_RELEASE  = 3'd5;
	localparam logic [2:0] REG_MAKEUP   = 3'd6;
	localparam logic [2:0] REG_MIX      = 3'd7;

	localparam logic signed [15:0] DB_FLOOR   = -16'sd25600;
	localparam logic signed [15:0] ENV_MIN    = -16'sd15360;
	localparam logic signed [15:0] MAKEUP_MAX = 16'sd6144;
	localparam logic signed [15:0] GAIN_LIMIT = 16'sd6144;
	localparam logic [16:0]        MIX_ONE    = 17'd65536;
	localparam logic [12:0]        RATIO_ONE  = 13'd256;

	localparam logic signed [23:0] EXP_K   = 24'sd2786635;
	localparam logic signed [20:0] LOG_K   = 21'sd394566;
	localparam logic [16:0]        POLY_C3 = 17'd5116;
	localparam logic [16:0]        POLY_C2 = 17'd14815;
	localparam logic [16:0]        POLY_C1 = 17'd45602;
	localparam logic [17:0]        POLY_C0 = 18'd65536;

	typedef struct packed {
		logic load;
		logic wet_en;
		logic mul_en;
		logic mix_en;
		logic sum_en;
		logic bypass;
	} lane_ctl_t;

endpackage
`default_nettype wire

FILE: sv/feedforward_peak_compressor_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// feedforward_peak_compressor_core
// Feed-forward peak compressor with dB envelope, makeup and dry/wet mix.
// ----------------------------------------------------------------------------
// One frame is in flight at a time. The time of a compressed frame from
// acceptance to result grows with N (0 to SAMPLE_BITS+2), the normalize
// shift count of the level detector. It is set by the level detector (one
// bit of shift per cycle, then sixteen squaring steps), for a zero peak by
// the slope divider, and by two passes through the shared dB-to-linear unit.
// With enable low a frame goes straight to the output stage and
// gain_reduction reads 0. A finished frame holds in its last stage while the
// previous result waits for out_ready. A new frame is taken while the last
// result waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module feedforward_peak_compressor_core #(
	parameter int SAMPLE_BITS = ffpc_pkg::SAMPLE_BITS
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire logic [ffpc_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] ch0_sample,
	input  wire logic signed [SAMPLE_BITS-1:0] ch1_sample,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic signed [SAMPLE_BITS-1:0]      ch0_out,
	output logic signed [SAMPLE_BITS-1:0]      ch1_out,
	output logic signed [14:0]                 gain_reduction
);
	localparam int SB = SAMPLE_BITS;
	localparam int NCH = ffpc_pkg::CHANNELS;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b000000000001,
		S_INGAIN = 12'b000000000010,
		S_PEAK   = 12'b000000000100,
		S_LOG    = 12'b000000001000,
		S_ENV    = 12'b000000010000,
		S_ENVUPD = 12'b000000100000,
		S_GAIN   = 12'b000001000000,
		S_MIX    = 12'b000010000000,
		S_SUM    = 12'b000100000000,
		S_DONE   = 12'b001000000000,
		S_WET    = 12'b010000000000,
		S_SPARE  = 12'b100000000000
	} seq_state_t;

	// configuration
	logic               en_q;
	logic signed [13:0] in_gain_q;
	logic signed [14:0] thr_q;
	logic [12:0]        ratio_q;
	logic [15:0]        atk_q;
	logic [15:0]        rel_q;
	logic               mk_q;
	logic [16:0]        mix_q;

	seq_state_t         state_q;
	logic               bypass_q;
	logic signed [15:0] env_q;
	logic signed [34:0] ovp_q;
	logic               over_pos_q;
	logic signed [33:0] mkp_q;
	logic signed [37:0] dp_q;
	logic signed [15:0] mkdb_q;
	logic               out_valid_q;
	logic signed [SB-1:0] out_q [NCH];
	logic signed [14:0] gr_q;

	ffpc_pkg::lane_ctl_t ctl;
	logic signed [SB-1:0] samp_a [NCH];
	logic [SB+2:0]        mag_a [NCH];
	logic signed [SB-1:0] y_a [NCH];
	logic [SB+2:0]        peak;

	logic               wr;
	logic               accept;
	logic signed [15:0] in_db;
	logic [16:0]        mix_eff;
	logic               exp_start;
	logic signed [15:0] exp_d;
	logic               exp_busy;
	logic [24:0]        exp_gain;
	logic               log_start;
	logic               log_busy;
	logic signed [15:0] db;
	logic               slope_busy;
	logic [16:0]        slope;
	logic signed [16:0] over;
	logic signed [15:0] neg_thr;
	logic signed [19:0] target;
	logic signed [20:0] diff;
	logic [15:0]        alpha;
	logic signed [16:0] mk_sh;
	logic signed [38:0] dp_r;
	logic signed [23:0] env_sum;
	logic signed [15:0] env_new;
	logic signed [15:0] env_mk;
	logic               out_free;

	assign pready   = 1'b1;
	assign wr       = psel && penable && pwrite;
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q      <= 1'b0;
			in_gain_q <= '0;
			thr_q     <= '0;
			ratio_q   <= 13'd256;
			atk_q     <= 16'hFFFF;
			rel_q     <= 16'hFFFF;
			mk_q      <= 1'b0;
			mix_q     <= ffpc_pkg::MIX_ONE;
		end else if (wr) begin
			case (paddr[4:2])
				ffpc_pkg::REG_ENABLE:  en_q      <= pwdata[0];
				ffpc_pkg::REG_IN_GAIN: in_gain_q <= pwdata[13:0];
				ffpc_pkg::REG_THRESH:  thr_q     <= pwdata[14:0];
				ffpc_pkg::REG_RATIO:   ratio_q   <= pwdata[12:0];
				ffpc_pkg::REG_ATTACK:  atk_q     <= pwdata[15:0];
				ffpc_pkg::REG_RELEASE: rel_q     <= pwdata[15:0];
				ffpc_pkg::REG_MAKEUP:  mk_q      <= pwdata[0];
				ffpc_pkg::REG_MIX:     mix_q     <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			ffpc_pkg::REG_ENABLE:  prdata = {31'b0, en_q};
			ffpc_pkg::REG_IN_GAIN: prdata = {18'b0, in_gain_q};
			ffpc_pkg::REG_THRESH:  prdata = {17'b0, thr_q};
			ffpc_pkg::REG_RATIO:   prdata = {19'b0, ratio_q};
			ffpc_pkg::REG_ATTACK:  prdata = {16'b0, atk_q};
			ffpc_pkg::REG_RELEASE: prdata = {16'b0, rel_q};
			ffpc_pkg::REG_MAKEUP:  prdata = {31'b0, mk_q};
			ffpc_pkg::REG_MIX:     prdata = {15'b0, mix_q};
			default:               prdata = '0;
		endcase
	end

	always_comb begin
		if (16'(in_gain_q) > ffpc_pkg::GAIN_LIMIT) begin
			in_db = ffpc_pkg::GAIN_LIMIT;
		end else if (16'(in_gain_q) < -ffpc_pkg::GAIN_LIMIT) begin
			in_db = -ffpc_pkg::GAIN_LIMIT;
		end else begin
			in_db = 16'(in_gain_q);
		end
	end

	assign mix_eff = (mix_q > ffpc_pkg::MIX_ONE) ? ffpc_pkg::MIX_ONE : mix_q;

	// envelope arithmetic
	assign over    = 17'(db) - 17'(thr_q);
	assign neg_thr = -16'(thr_q);
	assign target  = over_pos_q ? -20'(ovp_q[34:16]) : 20'sd0;
	assign diff    = 21'(target) - 21'(env_q);
	assign alpha   = (target < 20'(env_q)) ? atk_q : rel_q;
	assign mk_sh   = mkp_q[33:17];
	assign dp_r    = 39'(dp_q) + 39'sd32768;
	assign env_sum = 24'(env_q) + 24'($signed(dp_r[38:16]));

	always_comb begin
		if (env_sum > 24'sd0) begin
			env_new = 16'sd0;
		end else if (env_sum < 24'(ffpc_pkg::ENV_MIN)) begin
			env_new = ffpc_pkg::ENV_MIN;
		end else begin
			env_new = env_sum[15:0];
		end
	end

	assign env_mk    = env_new + mkdb_q;
	assign exp_start = (accept && en_q) || (state_q == S_ENVUPD);
	assign exp_d     = (state_q == S_IDLE) ? in_db : env_mk;
	assign log_start = (state_q == S_PEAK);

	always_comb begin
		peak = '0;
		for (int c = 0; c < NCH; c++) begin
			if (mag_a[c] > peak) begin
				peak = mag_a[c];
			end
		end
	end

	always_comb begin
		ctl        = '0;
		ctl.load   = accept;
		ctl.bypass = bypass_q;
		case (state_q)
			S_INGAIN: ctl.wet_en = !exp_busy;
			S_GAIN:   ctl.mul_en = !exp_busy;
			S_MIX:    ctl.mix_en = 1'b1;
			S_SUM:    ctl.sum_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bypass_q    <= 1'b0;
			env_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						bypass_q <= !en_q;
						state_q  <= en_q ? S_INGAIN : S_SUM;
					end
				end
				S_INGAIN: begin
					if (!exp_busy) begin
						state_q <= S_WET;
					end
				end
				S_WET:  state_q <= S_PEAK;
				S_PEAK: state_q <= S_LOG;
				S_LOG: begin
					if (!log_busy && !slope_busy) begin
						state_q <= S_ENV;
					end
				end
				S_ENV: state_q <= S_ENVUPD;
				S_ENVUPD: begin
					env_q   <= env_new;
					state_q <= S_GAIN;
				end
				S_GAIN: begin
					if (!exp_busy) begin
						state_q <= S_MIX;
					end
				end
				S_MIX: state_q <= S_SUM;
				S_SUM: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LOG) begin
			ovp_q      <= over * $signed({1'b0, slope});
			over_pos_q <= (over > 17'sd0);
			mkp_q      <= neg_thr * $signed({1'b0, slope});
		end
		if (state_q == S_ENV) begin
			dp_q <= diff * $signed({1'b0, alpha});
			if (!mk_q || (mk_sh < 17'sd0)) begin
				mkdb_q <= '0;
			end else if (mk_sh > 17'(ffpc_pkg::MAKEUP_MAX)) begin
				mkdb_q <= ffpc_pkg::MAKEUP_MAX;
			end else begin
				mkdb_q <= mk_sh[15:0];
			end
		end
		if ((state_q == S_DONE) && out_free) begin
			for (int c = 0; c < NCH; c++) begin
				out_q[c] <= y_a[c];
			end
			gr_q <= bypass_q ? 15'sd0 : env_q[14:0];
		end
	end

	assign samp_a[0] = ch0_sample;
	assign samp_a[1] = ch1_sample;

	for (genvar g = 0; g < NCH; g++) begin : g_lane
		ffpc_lane #(.SB(SB)) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.sample (samp_a[g]),
			.gain   (exp_gain),
			.mix    (mix_eff),
			.mag    (mag_a[g]),
			.y      (y_a[g])
		);
	end

	ffpc_dbexp u_dbexp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (exp_start),
		.d      (exp_d),
		.busy   (exp_busy),
		.gain   (exp_gain)
	);

	ffpc_dblog #(.SB(SB)) u_dblog (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.p      (peak),
		.busy   (log_busy),
		.db     (db)
	);

	ffpc_slope u_slope (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && en_q),
		.ratio  (ratio_q),
		.busy   (slope_busy),
		.slope  (slope)
	);

	assign out_valid      = out_valid_q;
	assign ch0_out        = out_q[0];
	assign ch1_out        = out_q[1];
	assign gain_reduction = gr_q;

	`ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")
	`ASSERT_IMP(a_env_range, 1'b1, (env_q <= 16'sd0) && (env_q >= ffpc_pkg::ENV_MIN), "envelope out of range")
	`ASSERT_IMP(a_bypass_gr, out_valid && !en_q, gain_reduction == 15'sd0, "reduction shown in bypass")

endmodule
`default_nettype wire

FILE: sv/ffpc_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffpc_lane
// One channel: input gain, magnitude for the peak, gain and dry/wet mix.
// ----------------------------------------------------------------------------
module ffpc_lane #(
	parameter int SB = ffpc_pkg::SAMPLE_BITS
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire ffpc_pkg::lane_ctl_t ctl,
	input  wire logic signed [SB-1:0] sample,
	input  wire logic [24:0]         gain,
	input  wire logic [16:0]         mix,
	output logic [SB+2:0]            mag,
	output logic signed [SB-1:0]     y
);
	localparam int WET_W = SB + 4;
	localparam int W_W   = SB + 10;
	localparam logic signed [SB+12:0] Y_MAX = {{14{1'b0}}, {(SB-1){1'b1}}};
	localparam logic signed [SB+12:0] Y_MIN = {{14{1'b1}}, {(SB-1){1'b0}}};

	logic signed [SB-1:0]    dry_q;
	logic signed [WET_W-1:0] wet_s1;
	logic signed [SB+29:0]   p_s2;
	logic signed [SB+17:0]   m1_s3;
	logic signed [SB+27:0]   m2_s3;
	logic signed [SB-1:0]    y_s4;

	logic signed [SB+25:0] wprod;
	logic signed [SB+29:0] pprod;
	logic signed [W_W-1:0] w;
	logic signed [SB+17:0] m1;
	logic signed [SB+27:0] m2;
	logic signed [SB+28:0] sum;
	logic signed [SB+12:0] yf;
	logic signed [WET_W-1:0] wneg;

	assign wprod = dry_q * $signed({1'b0, gain});
	assign pprod = wet_s1 * $signed({1'b0, gain});
	assign w     = p_s2[SB+29:20];
	assign m1    = dry_q * $signed({1'b0, 17'(ffpc_pkg::MIX_ONE - mix)});
	assign m2    = w * $signed({1'b0, mix});
	assign sum   = (SB+29)'(m1_s3) + (SB+29)'(m2_s3) + (SB+29)'(32768);
	assign yf    = sum[SB+28:16];
	assign wneg  = -wet_s1;
	assign mag   = wet_s1[WET_W-1] ? wneg[SB+2:0] : wet_s1[SB+2:0];
	assign y     = y_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_s4 <= '0;
		end else begin
			if (ctl.sum_en) begin
				if (ctl.bypass) begin
					y_s4 <= dry_q;
				end else if (yf > Y_MAX) begin
					y_s4 <= Y_MAX[SB-1:0];
				end else if (yf < Y_MIN) begin
					y_s4 <= Y_MIN[SB-1:0];
				end else begin
					y_s4 <= yf[SB-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			dry_q <= sample;
		end
		if (ctl.wet_en) begin
			wet_s1 <= wprod[WET_W+19:20];
		end
		if (ctl.mul_en) begin
			p_s2 <= pprod;
		end
		if (ctl.mix_en) begin
			m1_s3 <= m1;
			m2_s3 <= m2;
		end
	end

endmodule
`default_nettype wire

FILE: sv/ffpc_dbexp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffpc_dbexp
// dB (Q8.8) to linear gain (Q.20): log2 scale, cubic for the fraction, shift.
// ----------------------------------------------------------------------------
module ffpc_dbexp (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  wire logic signed [15:0]  d,
	output logic                     busy,
	output logic [24:0]              gain
);
	logic [3:0]         st_q;
	logic signed [23:0] e_q;
	logic [16:0]        t_q;
	logic [17:0]        m_q;
	logic [24:0]        res_q;

	logic signed [39:0] eprod;
	logic [15:0]        f;
	logic signed [7:0]  ip;
	logic [16:0]        opa;
	logic [32:0]        tmul;
	logic [16:0]        tm_hi;
	logic [21:0]        m4;
	logic [7:0]         nsh;
	logic [3:0]         sh;
	logic [29:0]        val;

	assign eprod = d * ffpc_pkg::EXP_K;
	assign f     = e_q[15:0];
	assign ip    = e_q[23:16];
	assign opa   = st_q[0] ? ffpc_pkg::POLY_C3 : t_q;
	assign tmul  = opa * f;
	assign tm_hi = tmul[32:16];
	assign m4    = {m_q, 4'b0};
	assign nsh   = -ip;
	assign sh    = (ip > 8'sd8) ? 4'd8 : ip[3:0];

	always_comb begin
		if (!ip[7]) begin
			val = 30'(m4) << sh;
		end else if (nsh >= 8'd22) begin
			val = '0;
		end else begin
			val = 30'(m4 >> nsh[4:0]);
		end
	end

	assign busy = |st_q;
	assign gain = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else begin
			st_q <= {st_q[2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			e_q <= eprod[39:16];
		end
		if (st_q[0]) begin
			t_q <= ffpc_pkg::POLY_C2 + tm_hi;
		end
		if (st_q[1]) begin
			t_q <= ffpc_pkg::POLY_C1 + tm_hi;
		end
		if (st_q[2]) begin
			m_q <= ffpc_pkg::POLY_C0 + 18'(tm_hi);
		end
		if (st_q[3]) begin
			res_q <= val[24:0];
		end
	end

endmodule
`default_nettype wire

FILE: sv/ffpc_dblog.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffpc_dblog
// Peak magnitude to dB (Q8.8): normalize, sixteen squaring steps, scale.
// ----------------------------------------------------------------------------
module ffpc_dblog #(
	parameter int SB = ffpc_pkg::SAMPLE_BITS
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire logic [SB+2:0]      p,
	output logic                    busy,
	output logic signed [15:0]      db
);
	localparam int MAG_W = SB + 3;
	localparam int SW    = $clog2(MAG_W);
	localparam int LW    = SW + 18;
	localparam int PW    = LW + 21;

	typedef enum logic [4:0] {
		L_IDLE = 5'b00001,
		L_NORM = 5'b00010,
		L_SQR  = 5'b00100,
		L_MUL  = 5'b01000,
		L_FIN  = 5'b10000
	} log_state_t;

	log_state_t           state_q;
	logic [MAG_W-1:0]     norm_q;
	logic [SW-1:0]        s_q;
	logic [30:0]          y_q;
	logic [15:0]          frac_q;
	logic [3:0]           cnt_q;
	logic signed [PW-1:0] prod_q;
	logic signed [15:0]   db_q;

	logic [MAG_W+30:0]    ext;
	logic [61:0]          sq;
	logic signed [SW+1:0] expo;
	logic signed [LW-1:0] lv;
	logic signed [PW-25:0] dbf;

	assign ext  = {norm_q, 31'b0};
	assign sq   = y_q * y_q;
	assign expo = (SW+2)'(3) - $signed({2'b0, s_q});
	assign lv   = {expo, frac_q};
	assign dbf  = prod_q[PW-1:24];
	assign busy = (state_q != L_IDLE);
	assign db   = db_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
		end else begin
			case (state_q)
				L_IDLE: begin
					if (start && (p != '0)) begin
						state_q <= L_NORM;
					end
				end
				L_NORM: begin
					if (norm_q[MAG_W-1]) begin
						state_q <= L_SQR;
					end
				end
				L_SQR: begin
					if (cnt_q == 4'd15) begin
						state_q <= L_MUL;
					end
				end
				L_MUL: state_q <= L_FIN;
				L_FIN: state_q <= L_IDLE;
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: begin
				if (start) begin
					norm_q <= p;
					s_q    <= '0;
					cnt_q  <= '0;
					frac_q <= '0;
					if (p == '0) begin
						db_q <= ffpc_pkg::DB_FLOOR;
					end
				end
			end
			L_NORM: begin
				if (norm_q[MAG_W-1]) begin
					y_q <= ext[MAG_W+30:MAG_W];
				end else begin
					norm_q <= {norm_q[MAG_W-2:0], 1'b0};
					s_q    <= s_q + 1'b1;
				end
			end
			L_SQR: begin
				frac_q <= {frac_q[14:0], sq[61]};
				y_q    <= sq[61] ? sq[61:31] : sq[60:30];
				cnt_q  <= cnt_q + 1'b1;
			end
			L_MUL: begin
				prod_q <= lv * ffpc_pkg::LOG_K;
			end
			L_FIN: begin
				if (dbf < (PW-24)'(ffpc_pkg::DB_FLOOR)) begin
					db_q <= ffpc_pkg::DB_FLOOR;
				end else begin
					db_q <= dbf[15:0];
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

FILE: sv/ffpc_slope.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffpc_slope
// Compression slope 1 - 1/ratio in Q0.16 by restoring division of 2^24.
// ----------------------------------------------------------------------------
module ffpc_slope (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire logic [12:0]  ratio,
	output logic              busy,
	output logic [16:0]       slope
);
	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [12:0] r_q;
	logic [12:0] rem_q;
	logic [24:0] quo_q;

	logic [13:0] trial;
	logic        fits;

	assign trial = {rem_q, (cnt_q == 5'd24)};
	assign fits  = (trial >= {1'b0, r_q});
	assign busy  = busy_q;
	assign slope = ffpc_pkg::MIX_ONE - quo_q[16:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd24;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= (ratio < ffpc_pkg::RATIO_ONE) ? ffpc_pkg::RATIO_ONE : ratio;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? 13'(trial - {1'b0, r_q}) : trial[12:0];
			quo_q <= {quo_q[23:0], fits};
		end
	end

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the feed-forward peak compressor core: APB register
// setup, valid/ready frame traffic with random gaps and stalls, and a bit-exact
// frame model that predicts every output item and checks them in order.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int SB = ffpc_pkg::SAMPLE_BITS;

	typedef struct {
		logic signed [SB-1:0] ch0;
		logic signed [SB-1:0] ch1;
		logic signed [14:0]   gr;
	} frame_res_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [ffpc_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0]               pwdata = '0;
	logic [31:0]               prdata;
	logic                      pready;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic signed [SB-1:0]      ch0_sample = '0;
	logic signed [SB-1:0]      ch1_sample = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [SB-1:0]      ch0_out;
	logic signed [SB-1:0]      ch1_out;
	logic signed [14:0]        gain_reduction;

	frame_res_t                frame_q[$];
	int                        err_cnt = 0;
	bit                        quiet = 1'b0;
	int                        stall_cnt = 0;
	logic [31:0]               shadow[8];
	longint                    env_db;
	int                        reg_w[8] = '{1, 14, 15, 13, 16, 16, 1, 17};

	feedforward_peak_compressor_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.ch0_sample(ch0_sample), .ch1_sample(ch1_sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.ch0_out(ch0_out), .ch1_out(ch1_out), .gain_reduction(gain_reduction)
	);

	always #6 clk = ~clk;

	function automatic longint db_to_gain(longint d);
		longint e, ip;
		longint unsigned f, t, m;
		e = (d * 64'sd2786635) >>> 16;
		ip = e >>> 16;
		f = e - ip * 65536;
		t = 5116;
		t = 14815 + ((t * f) >> 16);
		t = 45602 + ((t * f) >> 16);
		m = (65536 + ((t * f) >> 16)) << 4;
		if (ip >= 0) begin
			if (ip > 8) ip = 8;
			return m << ip;
		end
		if (ip < -40) ip = -40;
		return m >> (-ip);
	endfunction

	function automatic longint peak_to_db(longint unsigned p);
		int n;
		longint unsigned y;
		longint fr, l, db;
		if (p == 0) return -25600;
		n = 63;
		while (p[n] == 1'b0) n--;
		y = (n <= 30) ? (p << (30 - n)) : (p >> (n - 30));
		fr = 0;
		for (int i = 0; i < 16; i++) begin
			y = (y * y) >> 30;
			fr = fr << 1;
			if (y >= 64'd2147483648) begin
				fr = fr | 1;
				y = y >> 1;
			end
		end
		l = longint'(n - (SB - 1)) * 65536 + fr;
		db = (l * 64'sd394566) >>> 24;
		return db < -25600 ? -25600 : db;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic frame_res_t compress_frame(logic signed [SB-1:0] x0,
		logic signed [SB-1:0] x1);
		frame_res_t r;
		longint dry[2], wet[2], y[2];
		longint in_db, thr, ratio, slope, ingain, over, target, alpha, makeup, gain, mix;
		longint unsigned pk, a;
		dry[0] = x0;
		dry[1] = x1;
		if (!shadow[ffpc_pkg::REG_ENABLE][0]) begin
			r.ch0 = x0;
			r.ch1 = x1;
			r.gr = '0;
			return r;
		end
		in_db = clip(longint'($signed(shadow[ffpc_pkg::REG_IN_GAIN][13:0])), -6144, 6144);
		thr = longint'($signed(shadow[ffpc_pkg::REG_THRESH][14:0]));
		ratio = shadow[ffpc_pkg::REG_RATIO] < 256 ? 256 : shadow[ffpc_pkg::REG_RATIO];
		slope = 65536 - (64'sd16777216 / ratio);
		ingain = db_to_gain(in_db);
		pk = 0;
		for (int c = 0; c < 2; c++) begin
			wet[c] = (dry[c] * ingain) >>> 20;
			a = wet[c] < 0 ? -wet[c] : wet[c];
			if (a > pk) pk = a;
		end
		over = peak_to_db(pk) - thr;
		target = over > 0 ? -((over * slope) >>> 16) : 0;
		alpha = target < env_db ? shadow[ffpc_pkg::REG_ATTACK] : shadow[ffpc_pkg::REG_RELEASE];
		env_db = clip(env_db + (((target - env_db) * alpha + 32768) >>> 16), -15360, 0);
		makeup = 0;
		if (shadow[ffpc_pkg::REG_MAKEUP][0]) makeup = clip((-thr * slope) >>> 17, 0, 6144);
		gain = db_to_gain(env_db + makeup);
		mix = shadow[ffpc_pkg::REG_MIX] > 65536 ? 65536 : shadow[ffpc_pkg::REG_MIX];
		for (int c = 0; c < 2; c++) begin
			y[c] = (dry[c] * (65536 - mix) + ((wet[c] * gain) >>> 20) * mix + 32768) >>> 16;
			y[c] = clip(y[c], -(64'sd1 <<< (SB - 1)), (64'sd1 <<< (SB - 1)) - 1);
		end
		r.ch0 = y[0][SB-1:0];
		r.ch1 = y[1][SB-1:0];
		r.gr = env_db[14:0];
		return r;
	endfunction

	task automatic report(string what);
		$display("mismatch: %s", what);
		err_cnt++;
	endtask

	function automatic int gap_len();
		int k;
		if (quiet) return 0;
		k = $urandom_range(0, 99);
		if (k < 60) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		if (stall_cnt > 0) begin
			out_ready <= 1'b0;
			stall_cnt <= stall_cnt - 1;
		end else if (quiet || $urandom_range(0, 99) < 70) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= 1'b0;
			stall_cnt <= gap_len();
		end
	end

	always @(posedge clk) begin
		frame_res_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (frame_q.size() == 0) begin
				report("output item with none expected");
			end else begin
				exp_r = frame_q.pop_front();
				if (ch0_out !== exp_r.ch0)
					report($sformatf("ch0_out %0d exp %0d", ch0_out, exp_r.ch0));
				if (ch1_out !== exp_r.ch1)
					report($sformatf("ch1_out %0d exp %0d", ch1_out, exp_r.ch1));
				if (gain_reduction !== exp_r.gr)
					report($sformatf("gain_reduction %0d exp %0d", gain_reduction, exp_r.gr));
			end
		end
	end

	task automatic send_frame(logic signed [SB-1:0] x0, logic signed [SB-1:0] x1);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		ch0_sample <= x0;
		ch1_sample <= x1;
		do @(posedge clk); while (!in_ready);
		frame_q.push_back(compress_frame(x0, x1));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (frame_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ffpc_pkg::ADDR_W'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		shadow[idx] = val & ((32'd1 << reg_w[idx]) - 1);
		@(posedge clk);
	endtask

	task automatic load_regs(logic [31:0] v[8]);
		wait_idle();
		for (int i = 0; i < 8; i++) reg_write(3'(i), v[i]);
	endtask

	function automatic logic signed [SB-1:0] rand_sample();
		logic signed [SB-1:0] s;
		s = SB'($urandom);
		case ($urandom_range(0, 3))
			0: return s;
			1: return s >>> $urandom_range(0, SB - 1);
			2: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
			default: return s >>> $urandom_range(4, 12);
		endcase
	endfunction

	task automatic send_extremes();
		send_frame(24'sh000000, 24'sh000000);
		send_frame(24'sh7fffff, 24'sh800000);
		send_frame(24'sh800000, 24'sh7fffff);
		send_frame(24'sh7fffff, 24'sh7fffff);
		send_frame(24'sh800000, 24'sh800000);
		send_frame(24'sh000001, -24'sd1);
		send_frame(24'sh001000, 24'sh000000);
	endtask

	task automatic test_bypass();
		send_extremes();
	endtask

	task automatic test_directed();
		load_regs('{1, 0, 32'h7e00, 1024, 20000, 3000, 1, 65536});
		send_extremes();
		load_regs('{1, 32'h2000, 32'h4000, 100, 0, 0, 1, 32'h1ffff});
		send_extremes();
		load_regs('{1, 32'h1fff, 32'h4400, 5120, 65535, 1, 1, 0});
		send_extremes();
		load_regs('{1, 6144, 0, 5120, 65535, 65535, 1, 32768});
		send_extremes();
	endtask

	task automatic test_random(int phases, int per_phase);
		logic [31:0] v[8];
		for (int p = 0; p < phases; p++) begin
			v[ffpc_pkg::REG_ENABLE] = 32'($urandom_range(0, 9) != 0);
			v[ffpc_pkg::REG_IN_GAIN] = $urandom;
			v[ffpc_pkg::REG_THRESH] = $urandom_range(0, 3) == 0 ? $urandom :
				32'h8000 - $urandom_range(0, 15360);
			v[ffpc_pkg::REG_RATIO] = $urandom;
			v[ffpc_pkg::REG_ATTACK] = $urandom_range(0, 7) == 0 ? 0 : $urandom;
			v[ffpc_pkg::REG_RELEASE] = $urandom_range(0, 7) == 0 ? 0 : $urandom;
			v[ffpc_pkg::REG_MAKEUP] = $urandom;
			v[ffpc_pkg::REG_MIX] = $urandom_range(0, 2) == 0 ? 65536 : $urandom;
			load_regs(v);
			quiet = (p % 5 == 4);
			for (int i = 0; i < per_phase; i++) send_frame(rand_sample(), rand_sample());
			quiet = 1'b0;
		end
	endtask

	initial begin
		shadow = '{0, 0, 0, 256, 65535, 65535, 0, 65536};
		env_db = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_bypass();
		test_directed();
		test_random(20, 35);
		wait_idle();
		if (err_cnt == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

	initial begin
		#30ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/ffpc_pkg.sv
sv/ffpc_lane.sv
sv/ffpc_dbexp.sv
sv/ffpc_dblog.sv
sv/ffpc_slope.sv
sv/feedforward_peak_compressor_core.sv
tb/tb_top.sv
